>>> sv/pf2rgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pf2rgb_pkg
// Shared types and constants for the pixel format to RGB888 converter.
// ----------------------------------------------------------------------------
package pf2rgb_pkg;

    // Source pixel formats, as held in the format register.
    typedef enum logic [1:0] {
        FMT_GREY   = 2'd0,
        FMT_RGB565 = 2'd1,
        FMT_YUYV   = 2'd2,
        FMT_RGB24  = 2'd3
    } fmt_t;

    // One pixel request for the conversion pipeline. When yuv is set the
    // bytes are Y, U and V; otherwise they are the finished red, green, blue.
    typedef struct packed {
        logic       yuv;
        logic [7:0] d0;
        logic [7:0] d1;
        logic [7:0] d2;
        logic       last;
    } pix_t;

    localparam int AccW = 20;

    // BT.601 integer coefficients.
    localparam logic signed [AccW-1:0] CoefY  = 20'sd298;
    localparam logic signed [AccW-1:0] CoefRv = 20'sd409;
    localparam logic signed [AccW-1:0] CoefGu = 20'sd100;
    localparam logic signed [AccW-1:0] CoefGv = 20'sd208;
    localparam logic signed [AccW-1:0] CoefBu = 20'sd516;
    localparam logic signed [AccW-1:0] RoundK = 20'sd128;

    localparam logic [7:0] YOffset    = 8'd16;
    localparam logic [8:0] ChromaBias = 9'd128;

endpackage

>>> sv/pixel_format_to_rgb888_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_to_rgb888_core
// Camera pixel stream to RGB888 converter for grey, RGB565, YUYV and RGB24.
// ----------------------------------------------------------------------------
// Path: a word lands in the input hold stage when it is accepted, then its
//   pixels pass the four pipeline stages (offset removal, multiply, sum,
//   output register) to m_; a YUYV second pixel follows the first.
// Throughput: one output pixel per cycle while m_tready is high; a grey, RGB565
//   or RGB24 word is taken every cycle, a YUYV word is held until both its pixels are taken.
// Reset: aresetn is synchronous and active low; it empties all stages and
//   sets the source format to grey.
module pixel_format_to_rgb888_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Format register write port.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,      // pixel_format
    // Source words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,        // byte0 [7:0], byte1 [15:8],
                                        // byte2 [23:16], byte3 [31:24]
    input  logic        s_tlast,        // last_in
    // RGB888 pixel words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,        // red [7:0], green [15:8], blue [23:16]
    output logic        m_tlast         // last_out
);
    import pf2rgb_pkg::*;

    // The format must only be rewritten while the block is idle (the block itself
    // does not enforce this), so the live register value applies to every word in flight.
    fmt_t        pixel_format_reg;

    // Input hold stage. A YUYV word stays here while its two pixels are handed
    // to the pipeline; phase_reg tells which one is next.
    logic        hold_valid_reg;
    logic [31:0] hold_data_reg;
    logic        hold_last_reg;
    logic        phase_reg;

    logic [7:0]  b0, b1, b2, b3;
    logic [4:0]  r5, b5;
    logic [5:0]  g6;
    pix_t        pix;
    logic        final_pix;
    logic        conv_ready;
    logic        take;
    logic        s_accept;
    logic [7:0]  red, green, blue;

    assign b0 = hold_data_reg[7:0];
    assign b1 = hold_data_reg[15:8];
    assign b2 = hold_data_reg[23:16];
    assign b3 = hold_data_reg[31:24];

    // RGB565 arrives low byte first: rrrrrggg gggbbbbb across byte1:byte0.
    assign r5 = b1[7:3];
    assign g6 = {b1[2:0], b0[7:5]};
    assign b5 = b0[4:0];

    // Build the pixel request for the pipeline. Direct formats are finished
    // here; YUYV sends Y0 then Y1 with the shared U and V, and only the second
    // pixel carries the frame's last flag.
    always_comb begin
        pix       = '0;
        final_pix = 1'b1;
        unique case (pixel_format_reg)
            FMT_GREY: begin
                pix = '{yuv: 1'b0, d0: b0, d1: b0, d2: b0, last: hold_last_reg};
            end
            FMT_RGB565: begin
                pix = '{yuv: 1'b0,
                        d0: {r5, r5[4:2]},
                        d1: {g6, g6[5:4]},
                        d2: {b5, b5[4:2]},
                        last: hold_last_reg};
            end
            FMT_YUYV: begin
                pix = '{yuv: 1'b1,
                        d0: phase_reg ? b2 : b0,
                        d1: b1,
                        d2: b3,
                        last: phase_reg & hold_last_reg};
                final_pix = phase_reg;
            end
            FMT_RGB24: begin
                pix = '{yuv: 1'b0, d0: b0, d1: b1, d2: b2, last: hold_last_reg};
            end
        endcase
    end

    assign take     = hold_valid_reg && conv_ready;
    assign s_tready = !hold_valid_reg || (conv_ready && final_pix);
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_format_reg <= FMT_GREY;
            hold_valid_reg   <= 1'b0;
            phase_reg        <= 1'b0;
        end else begin
            if (cfg_we) begin
                pixel_format_reg <= fmt_t'(cfg_wdata);
            end
            if (s_accept) begin
                hold_valid_reg <= 1'b1;
            end else if (take && final_pix) begin
                hold_valid_reg <= 1'b0;
            end
            if (take) begin
                phase_reg <= !final_pix;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            hold_data_reg <= s_tdata;
            hold_last_reg <= s_tlast;
        end
    end

    pf2rgb_conv u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (hold_valid_reg),
        .in_ready  (conv_ready),
        .in_pix    (pix),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_red   (red),
        .out_green (green),
        .out_blue  (blue),
        .out_last  (m_tlast)
    );

    assign m_tdata = {blue, green, red};

    // The second-pixel phase only exists for YUYV words.
    a_phase_yuyv_only: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> (hold_valid_reg && pixel_format_reg == FMT_YUYV))
        else $error("second-pixel phase outside a held YUYV word");
    // A freshly accepted word always starts with its first pixel.
    a_new_word_phase0: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (hold_valid_reg && !phase_reg))
        else $error("accepted word not held at its first pixel");
    // Once the second YUYV pixel is taken the phase returns to the start.
    a_phase_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg && conv_ready) |=> !phase_reg)
        else $error("phase did not return after the second pixel");

endmodule

>>> sv/pf2rgb_conv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pf2rgb_conv
// Four-stage pipeline: offset removal, multiply, sum, YUV clamp to 8 bits.
// ----------------------------------------------------------------------------
module pf2rgb_conv (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  pf2rgb_pkg::pix_t   in_pix,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_red,
    output logic [7:0]         out_green,
    output logic [7:0]         out_blue,
    output logic               out_last
);
    import pf2rgb_pkg::*;

    // Stage 1: Y offset floored at zero, chroma made signed.
    logic                    v1_reg;
    pix_t                    p1_reg;
    logic [7:0]              c1_reg;
    logic signed [8:0]       u1_reg, v1s_reg;
    // Stage 2: products.
    logic                    v2_reg;
    pix_t                    p2_reg;
    logic signed [AccW-1:0]  pc2_reg, prv2_reg, pgu2_reg, pgv2_reg, pbu2_reg;
    // Stage 3: sums.
    logic                    v3_reg;
    pix_t                    p3_reg;
    logic signed [AccW-1:0]  ar3_reg, ag3_reg, ab3_reg;
    // Stage 4: output register.
    logic                    v4_reg;
    logic [7:0]              r4_reg, g4_reg, b4_reg;
    logic                    l4_reg;

    logic adv1, adv2, adv3, adv4;

    function automatic logic [7:0] sat8(input logic signed [AccW-1:0] acc);
        logic [7:0] res;
        if (acc[AccW-1]) begin
            res = 8'd0;
        end else if (|acc[AccW-2:16]) begin
            res = 8'hff;
        end else begin
            res = acc[15:8];
        end
        return res;
    endfunction

    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            p1_reg  <= in_pix;
            c1_reg  <= (in_pix.d0 > YOffset) ? (in_pix.d0 - YOffset) : 8'd0;
            u1_reg  <= $signed({1'b0, in_pix.d1} - ChromaBias);
            v1s_reg <= $signed({1'b0, in_pix.d2} - ChromaBias);
        end
        if (adv2) begin
            p2_reg   <= p1_reg;
            pc2_reg  <= $signed({{(AccW-8){1'b0}}, c1_reg}) * CoefY;
            prv2_reg <= AccW'(v1s_reg) * CoefRv;
            pgu2_reg <= AccW'(u1_reg) * CoefGu;
            pgv2_reg <= AccW'(v1s_reg) * CoefGv;
            pbu2_reg <= AccW'(u1_reg) * CoefBu;
        end
        if (adv3) begin
            p3_reg  <= p2_reg;
            ar3_reg <= pc2_reg + prv2_reg + RoundK;
            ag3_reg <= pc2_reg - pgu2_reg - pgv2_reg + RoundK;
            ab3_reg <= pc2_reg + pbu2_reg + RoundK;
        end
        if (adv4) begin
            l4_reg <= p3_reg.last;
            if (p3_reg.yuv) begin
                r4_reg <= sat8(ar3_reg);
                g4_reg <= sat8(ag3_reg);
                b4_reg <= sat8(ab3_reg);
            end else begin
                r4_reg <= p3_reg.d0;
                g4_reg <= p3_reg.d1;
                b4_reg <= p3_reg.d2;
            end
        end
    end

    assign out_valid = v4_reg;
    assign out_red   = r4_reg;
    assign out_green = g4_reg;
    assign out_blue  = b4_reg;
    assign out_last  = l4_reg;

    a_stage2_from_stage1: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(v2_reg) |-> $past(v1_reg))
        else $error("stage 2 filled without stage 1 holding a pixel");
    a_stage3_from_stage2: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(v3_reg) |-> $past(v2_reg))
        else $error("stage 3 filled without stage 2 holding a pixel");
    a_out_from_stage3: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(v4_reg) |-> $past(v3_reg))
        else $error("output filled without stage 3 holding a pixel");

endmodule
